/* design/xlb_pkg.sv */
// Shared constants, types and codes for the XOR linear basis unit.
package xlb_pkg;

   localparam int Bits = 64;
   localparam int VecW = 64;
   localparam int IdxW = $clog2(VecW);
   localparam int WaysW = 30;
   localparam int RankW = 7;
   localparam int RspDataW = 40;

   localparam logic [VecW-1:0] VecMask = {VecW{1'b1}} >> (VecW - Bits);
   localparam logic [WaysW-1:0] PrimeMod = WaysW'(1000000007);
   localparam logic [RankW-1:0] RankMax = RankW'(Bits);

   localparam logic CmdInsert = 1'b0;
   localparam logic CmdQuery = 1'b1;

   // One request as it walks down the chain of basis cells.
   typedef struct packed {
      logic valid;
      logic cmd;
      logic done;
      logic [VecW-1:0] vec;
   } stage_type;

endpackage

/* design/xlb_cell.sv */
// One basis cell: holds the row for one leading bit and reduces passing requests.
module xlb_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    enable,
   input  logic [xlb_pkg::IdxW-1:0] cell_index,
   input  xlb_pkg::stage_type      up_stage,
   output xlb_pkg::stage_type      down_stage
);

   logic [xlb_pkg::VecW-1:0] row_ff;
   logic [xlb_pkg::VecW-1:0] row_in;
   xlb_pkg::stage_type       stage_ff;
   xlb_pkg::stage_type       stage_in;
   logic                     hit;
   logic                     row_used;

   // A row is in use exactly when its own leading bit is set.
   assign row_used = row_ff[cell_index];
   assign hit = up_stage.valid && !up_stage.done && up_stage.vec[cell_index];

   always_comb begin
      stage_in = up_stage;
      row_in = row_ff;
      if (hit && row_used) begin
         stage_in.vec = up_stage.vec ^ row_ff;
      end
      if (hit && !row_used) begin
         stage_in.done = 1'b1;
         if (enable && up_stage.cmd == xlb_pkg::CmdInsert) begin
            row_in = up_stage.vec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         row_ff <= '0;
      end else begin
         row_ff <= row_in;
         if (enable) begin
            stage_ff <= stage_in;
         end
      end
   end

   assign down_stage = stage_ff;

endmodule

/* design/xlb_tail.sv */
// End of the chain: keeps rank and the free power, and registers the result.
module xlb_tail (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     enable,
   input  xlb_pkg::stage_type       last_stage,
   output logic                     out_valid,
   output logic                     out_flag,
   output logic [xlb_pkg::WaysW-1:0] out_ways,
   output logic [xlb_pkg::RankW-1:0] out_rank
);

   logic [xlb_pkg::RankW-1:0] rank_ff;
   logic [xlb_pkg::RankW-1:0] rank_in;
   logic [xlb_pkg::WaysW-1:0] power_ff;
   logic [xlb_pkg::WaysW-1:0] power_in;
   logic [xlb_pkg::WaysW:0]   power_twice;
   logic                      valid_ff;
   logic                      valid_in;
   logic                      flag_ff;
   logic                      flag_in;
   logic [xlb_pkg::WaysW-1:0] ways_ff;
   logic [xlb_pkg::WaysW-1:0] ways_in;
   logic [xlb_pkg::RankW-1:0] rank_out_ff;

   // The power stays below the prime, so one compare and subtract suffices.
   assign power_twice = {power_ff, 1'b0};

   always_comb begin
      rank_in = rank_ff;
      power_in = power_ff;
      flag_in = 1'b0;
      ways_in = '0;
      valid_in = valid_ff;
      if (enable) begin
         valid_in = last_stage.valid;
         if (last_stage.valid) begin
            if (last_stage.cmd == xlb_pkg::CmdInsert) begin
               if (last_stage.done) begin
                  flag_in = 1'b1;
                  if (rank_ff < xlb_pkg::RankMax) begin
                     rank_in = rank_ff + 1'b1;
                  end
               end else if (power_twice >= {1'b0, xlb_pkg::PrimeMod}) begin
                  power_in = xlb_pkg::WaysW'(power_twice - {1'b0, xlb_pkg::PrimeMod});
               end else begin
                  power_in = power_twice[xlb_pkg::WaysW-1:0];
               end
            end else if (!last_stage.done) begin
               flag_in = 1'b1;
               ways_in = power_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= '0;
         power_ff <= xlb_pkg::WaysW'(1);
         valid_ff <= 1'b0;
      end else begin
         rank_ff <= rank_in;
         power_ff <= power_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         flag_ff <= flag_in;
         ways_ff <= ways_in;
         rank_out_ff <= rank_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_flag = flag_ff;
   assign out_ways = ways_ff;
   assign out_rank = rank_out_ff;

endmodule

/* design/xor_linear_basis_unit.sv */
// Top level of the XOR linear basis unit: a chain of basis cells and a result stage.
//
// Each request walks down a chain of one cell per vector bit, top bit first, and its
// result is registered in the result stage; the chain holds many requests at once and
// accepts one request per cycle while the result slot is empty or its result is taken.
// A request stops reducing at the first set bit whose cell holds no row, and an insert
// stores its remainder there. Rank and the free power 2^(inserted - rank) mod 1000000007
// are updated in the result stage in request order. When the result is not taken, the
// whole chain holds and req_tready falls.
module xor_linear_basis_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [xlb_pkg::VecW-1:0]      req_tdata,  // vector_value
   input  logic [0:0]                    req_tuser,  // command
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [xlb_pkg::RspDataW-1:0]  rsp_tdata   // flag, ways_mod_prime, rank_now, pad
);

   logic                      enable;
   xlb_pkg::stage_type        chain [xlb_pkg::Bits+1];
   logic                      out_flag;
   logic [xlb_pkg::WaysW-1:0] out_ways;
   logic [xlb_pkg::RankW-1:0] out_rank;

   assign enable = !rsp_tvalid || rsp_tready;
   assign req_tready = enable;

   always_comb begin
      chain[0].valid = req_tvalid;
      chain[0].cmd = req_tuser[0];
      chain[0].done = 1'b0;
      chain[0].vec = req_tdata & xlb_pkg::VecMask;
   end

   for (genvar k = 0; k < xlb_pkg::Bits; k++) begin : g_cell
      xlb_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .enable     (enable),
         .cell_index (xlb_pkg::IdxW'(xlb_pkg::Bits - 1 - k)),
         .up_stage   (chain[k]),
         .down_stage (chain[k+1])
      );
   end

   xlb_tail u_tail (
      .clock      (clock),
      .reset      (reset),
      .enable     (enable),
      .last_stage (chain[xlb_pkg::Bits]),
      .out_valid  (rsp_tvalid),
      .out_flag   (out_flag),
      .out_ways   (out_ways),
      .out_rank   (out_rank)
   );

   assign rsp_tdata = {2'b00, out_rank, out_ways, out_flag};

endmodule

/* design/xlb_checker.sv */
// Port-level assertions for the XOR linear basis unit, bound to the top level.
module xlb_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_tready,
   input logic                         rsp_tvalid,
   input logic                         rsp_tready,
   input logic [xlb_pkg::RspDataW-1:0] rsp_tdata
);

   // No result can be pending right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   // A nonzero count only comes with a set flag.
   a_ways_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[30:1] != '0 |-> rsp_tdata[0])
      else $error("ways nonzero without flag");

   a_rank_max: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[37:31] <= xlb_pkg::RankMax)
      else $error("rank beyond vector width");

   // Requests are taken whenever the result slot is free or draining.
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready does not follow result stall");

endmodule

bind xor_linear_basis_unit xlb_checker u_xlb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
